// ----- rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Field widths fixed by the stream interface and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    // Width of a size or address field on the ports and in a header.
    localparam int unsigned FIELD_W = 13;

    // Padded widths of the stream payloads.
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 16;

    // Request kinds carried in s_tuser.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_EVAL   = 7'b0001000,
        ST_WR2    = 7'b0010000,
        ST_FWRITE = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit free-list allocator over a fixed arena
// Keeps block headers in an on-chip memory indexed by header byte offset and
// walks the singly linked free list with one shared compare/add datapath.
// ----------------------------------------------------------------------------
// Allocate: an accept step, then a memory read and a compare for each free-list
//   header visited, then a header write and a result; a miss ends after the
//   last header. Free: header read, header write, result.
// One request at a time; the header memory's single read port and single
//   write port set the pace of the walk.
// Reset (aresetn low, synchronous) and every heap_size write lead to writing
//   the initial free block header at offset 0 before taking requests.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
    parameter int unsigned HEAP_BYTES   = 4096,
    parameter int unsigned ALIGN_BYTES  = 4,
    parameter int unsigned HEADER_BYTES = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // Configuration: heap_size write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ffha_pkg::FIELD_W-1:0]     cfg_data,     // heap_size

    // Request channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [12:0] request_size, [25:13] data_address, [31:26] zero
    input  wire logic [ffha_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] kind (0 = allocate, 1 = free)
    input  wire logic [0:0]                       s_tuser,

    // Result channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [12:0] result_address, [15:13] zero
    output logic [ffha_pkg::M_TDATA_W-1:0]        m_tdata,
    // [0] granted
    output logic [0:0]                            m_tuser
);

    localparam int unsigned FW          = ffha_pkg::FIELD_W;
    // Headers live at any byte offset below the end of the arena.
    localparam int unsigned STORE_DEPTH = HEAP_BYTES + HEADER_BYTES;
    localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
    localparam int unsigned STEP_W      = $clog2(STORE_DEPTH + 1);
    // Wide enough for offset + size sums and a rounded 13-bit request.
    localparam int unsigned WIDE_W      = ((IDX_W > FW) ? IDX_W : FW) + 2;
    // Header entry: {size, next, next_valid}
    localparam int unsigned ENTRY_W     = FW + IDX_W + 1;

    // Reciprocal of the alignment, exact for any biased 13-bit request.
    localparam int unsigned RND_W       = FW + 1;
    localparam int unsigned RCP_SH      = RND_W + $clog2(ALIGN_BYTES);
    localparam int unsigned RCP_W       = RND_W + 1;
    localparam int unsigned PROD_W      = RND_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_M  =
        RCP_W'(((64'd1 << RCP_SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

    localparam logic [WIDE_W-1:0] HDR_W   = WIDE_W'(HEADER_BYTES);
    localparam logic [WIDE_W-1:0] ALIGN_W = WIDE_W'(ALIGN_BYTES);
    localparam logic [WIDE_W-1:0] HEAP_W  = WIDE_W'(HEAP_BYTES);
    localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(STORE_DEPTH);
    localparam logic [FW-1:0]     HEAP_RST = FW'(HEAP_BYTES);

    // Round a request up to the alignment: bias, divide by reciprocal
    // multiplication, then scale back by the alignment.
    function automatic logic [WIDE_W-1:0] round_up(input logic [FW-1:0] req);
        logic [RND_W-1:0]  biased;
        logic [PROD_W-1:0] prod;
        logic [RND_W-1:0]  units;
        biased   = RND_W'(req) + RND_W'(ALIGN_BYTES - 1);
        prod     = PROD_W'(biased) * PROD_W'(RCP_M);
        units    = RND_W'(prod >> RCP_SH);
        round_up = WIDE_W'(units) * ALIGN_W;
    endfunction

    // ------------------------------------------------------------------
    // Header memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] hdr_mem [STORE_DEPTH];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hdr_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= hdr_mem[mem_raddr];
        end
    end

    // Fields of the header just read
    logic [FW-1:0]    h_size;
    logic [IDX_W-1:0] h_next;
    logic             h_nv;
    assign {h_size, h_next, h_nv} = rd_data_reg;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    ffha_pkg::state_t  state_reg, state_next;
    logic [FW-1:0]     heap_size_reg, heap_size_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic              head_valid_reg, head_valid_next;
    logic [WIDE_W-1:0] sz_reg, sz_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]  pred_reg, pred_next;
    logic [FW-1:0]     pred_size_reg, pred_size_next;
    logic              at_head_reg, at_head_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              split_reg, split_next;
    logic              res_granted_reg, res_granted_next;
    logic [FW-1:0]     res_addr_reg, res_addr_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_granted_reg, m_granted_next;
    logic [FW-1:0]     m_addr_reg, m_addr_next;

    // Request fields
    logic              req_kind;
    logic [FW-1:0]     req_size;
    logic [FW-1:0]     req_daddr;
    assign req_kind  = s_tuser[0];
    assign req_size  = s_tdata[FW-1:0];
    assign req_daddr = s_tdata[2*FW-1:FW];

    // Shared compare/add datapath of the walk
    logic [WIDE_W-1:0] h_size_w, cur_w, nh_w, cfg_w, da_w, hoff_w;
    logic              fits, can_split, free_ok;
    assign h_size_w  = WIDE_W'(h_size);
    assign cur_w     = WIDE_W'(cur_reg);
    assign fits      = h_size_w >= sz_reg;
    assign can_split = h_size_w >= sz_reg + HDR_W + ALIGN_W;
    assign nh_w      = cur_w + h_size_w - sz_reg;
    assign cfg_w     = WIDE_W'(cfg_data);
    assign da_w      = WIDE_W'(req_daddr);
    assign hoff_w    = da_w - HDR_W;
    assign free_ok   = (da_w >= HDR_W) && (hoff_w < DEPTH_W);

    logic cfg_fire, s_fire;
    assign cfg_ready = (state_reg == ffha_pkg::ST_IDLE);
    assign s_tready  = (state_reg == ffha_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        state_next       = state_reg;
        heap_size_next   = heap_size_reg;
        head_next        = head_reg;
        head_valid_next  = head_valid_reg;
        sz_next          = sz_reg;
        cur_next         = cur_reg;
        cur_valid_next   = cur_valid_reg;
        pred_next        = pred_reg;
        pred_size_next   = pred_size_reg;
        at_head_next     = at_head_reg;
        steps_next       = steps_reg;
        split_next       = split_reg;
        res_granted_next = res_granted_reg;
        res_addr_next    = res_addr_reg;
        m_valid_next     = m_valid_reg;
        m_granted_next   = m_granted_reg;
        m_addr_next      = m_addr_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        // Drop the result once the sink takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ffha_pkg::ST_INIT: begin
                // Write the single initial free block at offset 0
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata       = {heap_size_reg, {IDX_W{1'b0}}, 1'b0};
                head_next       = '0;
                head_valid_next = 1'b1;
                state_next      = ffha_pkg::ST_IDLE;
            end

            ffha_pkg::ST_IDLE: begin
                if (cfg_fire) begin
                    // Saturate the heap size and rebuild the list
                    heap_size_next = (cfg_w > HEAP_W) ? HEAP_RST : cfg_data;
                    state_next     = ffha_pkg::ST_INIT;
                end else if (s_fire) begin
                    if (req_kind == ffha_pkg::KIND_ALLOC) begin
                        sz_next        = round_up(req_size);
                        cur_next       = head_reg;
                        cur_valid_next = head_valid_reg;
                        at_head_next   = 1'b1;
                        steps_next     = '0;
                        state_next     = ffha_pkg::ST_READ;
                    end else if (free_ok) begin
                        // Fetch the header to keep its size
                        cur_next   = hoff_w[IDX_W-1:0];
                        mem_re     = 1'b1;
                        mem_raddr  = hoff_w[IDX_W-1:0];
                        state_next = ffha_pkg::ST_FWRITE;
                    end else begin
                        res_granted_next = 1'b0;
                        res_addr_next    = '0;
                        state_next       = ffha_pkg::ST_DONE;
                    end
                end
            end

            ffha_pkg::ST_READ: begin
                // Bound the walk so a looped list still ends
                if (cur_valid_reg && (steps_reg < STEP_W'(STORE_DEPTH))) begin
                    mem_re     = 1'b1;
                    mem_raddr  = cur_reg;
                    steps_next = steps_reg + 1'b1;
                    state_next = ffha_pkg::ST_EVAL;
                end else begin
                    res_granted_next = 1'b0;
                    res_addr_next    = '0;
                    state_next       = ffha_pkg::ST_DONE;
                end
            end

            ffha_pkg::ST_EVAL: begin
                if (fits && can_split) begin
                    // Carve the tail: new header at the end of the free block
                    if (nh_w < DEPTH_W) begin
                        mem_we    = 1'b1;
                        mem_waddr = nh_w[IDX_W-1:0];
                        mem_wdata = {sz_reg[FW-1:0], {IDX_W{1'b0}}, 1'b0};
                    end
                    res_addr_next = FW'(nh_w + HDR_W);
                    split_next    = 1'b1;
                    state_next    = ffha_pkg::ST_WR2;
                end else if (fits) begin
                    // Unlink the whole block
                    if (at_head_reg) begin
                        head_next       = h_next;
                        head_valid_next = h_nv;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = pred_reg;
                        mem_wdata = {pred_size_reg, h_next, h_nv};
                    end
                    res_addr_next = FW'(cur_w + HDR_W);
                    split_next    = 1'b0;
                    state_next    = ffha_pkg::ST_WR2;
                end else begin
                    // Advance to the next free block
                    pred_next      = cur_reg;
                    pred_size_next = h_size;
                    at_head_next   = 1'b0;
                    cur_next       = h_next;
                    cur_valid_next = h_nv;
                    state_next     = ffha_pkg::ST_READ;
                end
            end

            ffha_pkg::ST_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                if (split_reg) begin
                    // Shrink the free block, keep its link
                    mem_wdata = {FW'(h_size_w - HDR_W - sz_reg), h_next, h_nv};
                end else begin
                    mem_wdata = {h_size, {IDX_W{1'b0}}, 1'b0};
                end
                res_granted_next = 1'b1;
                state_next       = ffha_pkg::ST_DONE;
            end

            ffha_pkg::ST_FWRITE: begin
                // Push the freed block onto the head of the list
                mem_we           = 1'b1;
                mem_waddr        = cur_reg;
                mem_wdata        = {h_size, head_reg, head_valid_reg};
                head_next        = cur_reg;
                head_valid_next  = 1'b1;
                res_granted_next = 1'b1;
                res_addr_next    = '0;
                state_next       = ffha_pkg::ST_DONE;
            end

            ffha_pkg::ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_addr_next    = res_addr_reg;
                    state_next     = ffha_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ffha_pkg::ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ffha_pkg::ST_INIT;
            heap_size_reg  <= HEAP_RST;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            heap_size_reg  <= heap_size_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sz_reg          <= sz_next;
        cur_reg         <= cur_next;
        cur_valid_reg   <= cur_valid_next;
        pred_reg        <= pred_next;
        pred_size_reg   <= pred_size_next;
        at_head_reg     <= at_head_next;
        steps_reg       <= steps_next;
        split_reg       <= split_next;
        res_granted_reg <= res_granted_next;
        res_addr_reg    <= res_addr_next;
        m_granted_reg   <= m_granted_next;
        m_addr_reg      <= m_addr_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {{(ffha_pkg::M_TDATA_W - FW){1'b0}}, m_addr_reg};
    assign m_tuser[0] = m_granted_reg;

endmodule

`default_nettype wire

// ----- tb/heap_grant_checker.sv -----
// ----------------------------------------------------------------------------
// heap_grant_checker: scoreboard for the first-fit heap allocator
// Watches the heap_size, request and result channels, keeps its own copy of
// the free list and block headers, and compares every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_grant_checker #(
    parameter int unsigned HEAP_BYTES   = 4096,
    parameter int unsigned ALIGN_BYTES  = 4,
    parameter int unsigned HEADER_BYTES = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [ffha_pkg::FIELD_W-1:0]     cfg_data,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    // [12:0] request_size, [25:13] data_address, [31:26] zero
    input  wire logic [ffha_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] kind
    input  wire logic [0:0]                       s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    // [12:0] result_address, [15:13] zero
    input  wire logic [ffha_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] granted
    input  wire logic [0:0]                       m_tuser,
    input  wire logic                             flush_check,
    output int                                    fail_count
);

    localparam int unsigned FIELD_W     = ffha_pkg::FIELD_W;
    localparam int unsigned STORE_DEPTH = HEAP_BYTES + HEADER_BYTES;
    localparam int unsigned MAX_REPORTS = 100;

    typedef struct packed {
        logic               granted;
        logic [FIELD_W-1:0] address;
    } grant_t;

    // Block headers, indexed by header byte offset.
    logic [FIELD_W-1:0] blk_size    [STORE_DEPTH];
    logic [FIELD_W-1:0] blk_next    [STORE_DEPTH];
    logic               blk_next_ok [STORE_DEPTH];
    logic [FIELD_W-1:0] list_top;
    logic               list_top_ok;

    grant_t      grants_due[$];
    int unsigned result_index;
    bit          flushed;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    function automatic void load_arena(input logic [FIELD_W-1:0] bytes_in);
        int unsigned usable;
        usable = (32'(bytes_in) > HEAP_BYTES) ? HEAP_BYTES : 32'(bytes_in);
        blk_size[0]    = FIELD_W'(usable);
        blk_next[0]    = '0;
        blk_next_ok[0] = 1'b0;
        list_top       = '0;
        list_top_ok    = 1'b1;
    endfunction

    function automatic grant_t predict_alloc(input logic [FIELD_W-1:0] req_bytes);
        grant_t      res;
        int unsigned need, cur, prev, steps, bsz, nxt, tail;
        logic        cur_ok, nxt_ok, at_head;
        res     = '0;
        need    = 32'(req_bytes);
        if (need % ALIGN_BYTES != 0) begin
            need += ALIGN_BYTES - need % ALIGN_BYTES;
        end
        cur     = 32'(list_top);
        cur_ok  = list_top_ok;
        prev    = 0;
        at_head = 1'b1;
        // A looped list is cut off after one pass over the whole store.
        for (steps = 0; cur_ok && steps < STORE_DEPTH; steps++) begin
            bsz    = (cur < STORE_DEPTH) ? 32'(blk_size[cur]) : 0;
            nxt    = (cur < STORE_DEPTH) ? 32'(blk_next[cur]) : 0;
            nxt_ok = (cur < STORE_DEPTH) ? blk_next_ok[cur] : 1'b0;
            if (bsz >= need) begin
                if (bsz >= need + HEADER_BYTES + ALIGN_BYTES) begin
                    // Split: the tail becomes the allocated block.
                    tail = cur + bsz - need;
                    if (tail < STORE_DEPTH) begin
                        blk_size[tail]    = FIELD_W'(need);
                        blk_next[tail]    = '0;
                        blk_next_ok[tail] = 1'b0;
                    end
                    if (cur < STORE_DEPTH) begin
                        blk_size[cur] = FIELD_W'(bsz - (HEADER_BYTES + need));
                    end
                    res.address = FIELD_W'(tail + HEADER_BYTES);
                end else begin
                    // Too small to split: unlink the whole block.
                    if (at_head) begin
                        list_top    = FIELD_W'(nxt);
                        list_top_ok = nxt_ok;
                    end else if (prev < STORE_DEPTH) begin
                        blk_next[prev]    = FIELD_W'(nxt);
                        blk_next_ok[prev] = nxt_ok;
                    end
                    if (cur < STORE_DEPTH) begin
                        blk_next[cur]    = '0;
                        blk_next_ok[cur] = 1'b0;
                    end
                    res.address = FIELD_W'(cur + HEADER_BYTES);
                end
                res.granted = 1'b1;
                return res;
            end
            prev    = cur;
            at_head = 1'b0;
            cur     = nxt;
            cur_ok  = nxt_ok;
        end
        return res;
    endfunction

    function automatic grant_t predict_free(input logic [FIELD_W-1:0] data_addr);
        grant_t      res;
        int unsigned hdr;
        res = '0;
        if (32'(data_addr) >= HEADER_BYTES &&
            32'(data_addr) - HEADER_BYTES < STORE_DEPTH) begin
            hdr              = 32'(data_addr) - HEADER_BYTES;
            blk_next[hdr]    = list_top;
            blk_next_ok[hdr] = list_top_ok;
            list_top         = FIELD_W'(hdr);
            list_top_ok      = 1'b1;
            res.granted      = 1'b1;
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        grant_t      got;
        grant_t      want;
        int unsigned i;
        if (!aresetn) begin
            for (i = 0; i < STORE_DEPTH; i++) begin
                blk_size[i]    = '0;
                blk_next[i]    = '0;
                blk_next_ok[i] = 1'b0;
            end
            load_arena(FIELD_W'(HEAP_BYTES));
            grants_due.delete();
            result_index = 0;
            fail_count   = 0;
            flushed      = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                load_arena(cfg_data);
            end
            if (m_tvalid && m_tready) begin
                got.granted = m_tuser[0];
                got.address = m_tdata[FIELD_W-1:0];
                if (grants_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request pending",
                                              result_index));
                end else begin
                    want = grants_due.pop_front();
                    if (got.granted !== want.granted) begin
                        report_mismatch($sformatf("result %0d granted %b, expected %b",
                                                  result_index, got.granted, want.granted));
                    end
                    if (got.address !== want.address) begin
                        report_mismatch($sformatf("result %0d address %0d, expected %0d",
                                                  result_index, got.address, want.address));
                    end
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == ffha_pkg::KIND_FREE) begin
                    grants_due.push_back(predict_free(s_tdata[2*FIELD_W-1:FIELD_W]));
                end else begin
                    grants_due.push_back(predict_alloc(s_tdata[FIELD_W-1:0]));
                end
            end
            if (flush_check && !flushed) begin
                while (grants_due.size() != 0) begin
                    want = grants_due.pop_front();
                    report_mismatch($sformatf("no result for request, expected %b/%0d",
                                              want.granted, want.address));
                end
                flushed = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/first_fit_heap_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb: stimulus and verdict for the heap allocator
// Drives directed and random allocate/free requests under three idle
// patterns and several heap sizes; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_tb;

    localparam int unsigned FIELD_W        = ffha_pkg::FIELD_W;
    localparam int unsigned HEAP_BYTES     = 4096;
    localparam int unsigned ALIGN_BYTES    = 4;
    localparam int unsigned HEADER_BYTES   = 8;
    localparam int unsigned STORE_DEPTH    = HEAP_BYTES + HEADER_BYTES;
    // Results arrive after the write of the last header.
    localparam int unsigned SETTLE_CYCLES  = 16;
    // The worst walk reads and compares each header in turn; this covers every
    // request walking a full looped list several times over.
    localparam int unsigned TIMEOUT_CYCLES = 64_000_000;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [FIELD_W-1:0]             cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    // [12:0] request_size, [25:13] data_address, [31:26] zero
    logic [ffha_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    // [0] kind
    logic [0:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    // [12:0] result_address, [15:13] zero
    logic [ffha_pkg::M_TDATA_W-1:0] m_tdata;
    // [0] granted
    logic [0:0]                     m_tuser;
    logic                           flush_check = 1'b0;
    int                             fail_count;

    int unsigned            src_idle_pct  = 38;
    int unsigned            sink_idle_pct = 48;
    int unsigned            requests_sent = 0;
    int unsigned            results_seen  = 0;
    // Data offsets handed out and not yet freed; frees draw from here.
    logic [FIELD_W-1:0]     live_blocks[$];
    logic [FIELD_W-1:0]     last_grant = '0;

    first_fit_heap_allocator #(
        .HEAP_BYTES   (HEAP_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    heap_grant_checker #(
        .HEAP_BYTES   (HEAP_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .flush_check (flush_check),
        .fail_count  (fail_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stall the result channel at random; a zero percentage keeps it open.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Track grants so later frees name real blocks.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[0] && m_tdata[FIELD_W-1:0] != '0) begin
                last_grant = m_tdata[FIELD_W-1:0];
                live_blocks.push_back(m_tdata[FIELD_W-1:0]);
            end
        end
    end

    // Present one request from a falling edge and return at the rising edge
    // that accepts it. Valid stays high so a back-to-back request needs no
    // second assignment in the same step.
    task automatic send_request(input logic kind, input logic [FIELD_W-1:0] req_bytes,
                                input logic [FIELD_W-1:0] data_addr);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(ffha_pkg::S_TDATA_W - 2 * FIELD_W){1'b0}}, data_addr, req_bytes};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    // Fill the ignored field with noise.
    task automatic alloc_req(input logic [FIELD_W-1:0] req_bytes);
        send_request(ffha_pkg::KIND_ALLOC, req_bytes, FIELD_W'($urandom));
    endtask

    task automatic free_req(input logic [FIELD_W-1:0] data_addr);
        send_request(ffha_pkg::KIND_FREE, FIELD_W'($urandom), data_addr);
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_seen != requests_sent) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write heap_size on an idle block; the list restarts, so forget live blocks.
    task automatic write_heap_size(input logic [FIELD_W-1:0] arena_bytes);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_data  <= arena_bytes;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        live_blocks.delete();
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                             input logic [FIELD_W-1:0] arena_bytes,
                             input int unsigned count);
        int unsigned        pick;
        int unsigned        sel;
        int unsigned        idx;
        logic [FIELD_W-1:0] req_bytes;
        write_heap_size(arena_bytes);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                // Address below the first header: ignored.
                free_req(FIELD_W'($urandom_range(HEADER_BYTES - 1)));
            end else if (pick < 3) begin
                // Header offset past the store: ignored.
                free_req(FIELD_W'($urandom_range(8191, STORE_DEPTH + HEADER_BYTES)));
            end else if (pick < 48 && live_blocks.size() != 0) begin
                idx = $urandom_range(live_blocks.size() - 1);
                free_req(live_blocks[idx]);
                live_blocks.delete(idx);
            end else begin
                // Mostly small blocks so lists grow long; a few near the arena size.
                sel = $urandom_range(99);
                if (sel < 70) begin
                    req_bytes = FIELD_W'($urandom_range(64));
                end else if (sel < 92) begin
                    req_bytes = FIELD_W'($urandom_range(512, 65));
                end else if (sel < 99) begin
                    req_bytes = FIELD_W'($urandom_range(HEAP_BYTES, 513));
                end else begin
                    req_bytes = FIELD_W'($urandom_range(HEAP_BYTES, HEAP_BYTES - 3));
                end
                alloc_req(req_bytes);
            end
        end
    endtask

    initial begin : stimulus
        logic [FIELD_W-1:0] blk;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Oversized heap: saturates to the full arena.
        write_heap_size(FIELD_W'(8191));
        alloc_req(FIELD_W'(0));             // zero-byte block split off the very end
        alloc_req(FIELD_W'(1));             // rounds up to one alignment unit
        alloc_req(FIELD_W'(4093));          // nothing fits
        alloc_req(FIELD_W'(HEAP_BYTES));    // nothing fits, top bit of the size
        free_req(FIELD_W'(0));              // below the first header: ignored
        free_req(FIELD_W'(HEADER_BYTES - 1));
        free_req(FIELD_W'(8191));           // past the store: ignored
        free_req(FIELD_W'(STORE_DEPTH));    // zero-byte block back to the head
        alloc_req(FIELD_W'(0));             // takes it whole
        alloc_req(FIELD_W'(4072));          // head block too small to split: unlink
        alloc_req(FIELD_W'(0));             // empty list
        free_req(FIELD_W'(HEADER_BYTES));
        free_req(FIELD_W'(4092));
        alloc_req(FIELD_W'(4));             // exact fit at the head
        alloc_req(FIELD_W'(5));

        // Empty arena, then the smallest splittable one.
        write_heap_size(FIELD_W'(0));
        alloc_req(FIELD_W'(0));
        alloc_req(FIELD_W'(0));
        write_heap_size(FIELD_W'(HEADER_BYTES + ALIGN_BYTES));
        alloc_req(FIELD_W'(0));
        alloc_req(FIELD_W'(4));

        // Free one block twice so the list loops on itself; a miss must still end.
        write_heap_size(FIELD_W'(HEAP_BYTES));
        alloc_req(FIELD_W'(100));
        quiesce();
        blk = last_grant;
        free_req(blk);
        free_req(blk);
        alloc_req(FIELD_W'(200));
        alloc_req(FIELD_W'(50));

        run_phase(38, 48, FIELD_W'(HEAP_BYTES), 667);
        run_phase(48, 38, FIELD_W'($urandom_range(600, 64)), 667);
        run_phase(0, 0, FIELD_W'(HEAP_BYTES - 1), 666);

        quiesce();
        flush_check <= 1'b1;
        @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
